// ===== src/sim_pkg.sv =====
// ----------------------------------------------------------------------------
// sim_pkg: shared types and constants of the sorted insert and merge block
// Holds the list depth default, the command and status codes, the controller
// state type and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package sim_pkg;

    // Fixed width of a stored or streamed value.
    localparam int DATA_W = 32;

    // Default number of entries in each list.
    localparam int LIST_DEPTH_DEF = 16;

    // Input command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_MERGE  = 1'b1;

    // List select codes.
    localparam logic LIST_FIRST  = 1'b0;
    localparam logic LIST_SECOND = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_MERGED   = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_insert;   // perform an insert and load its result
        logic ld_empty;    // load the both-lists-empty result
        logic start_merge; // clear the merge read pointers
        logic step_merge;  // emit one merged element and advance
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic both_empty;  // both lists hold no entries
        logic step_last;   // the pending merge step is the final one
    } t_dp_stat;

endpackage

// ===== src/sim_in_if.sv =====
// ----------------------------------------------------------------------------
// sim_in_if: command channel of the sorted insert and merge block
// Valid/ready channel carrying a command, a list select and a signed value.
// ----------------------------------------------------------------------------
interface sim_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic               list_select;
    logic signed [31:0] value;

    modport source (output valid, output command, output list_select, output value,
                    input ready);
    modport sink   (input valid, input command, input list_select, input value,
                    output ready);
endinterface

// ===== src/sim_out_if.sv =====
// ----------------------------------------------------------------------------
// sim_out_if: result channel of the sorted insert and merge block
// Valid/ready channel carrying a status, a signed value and a last marker.
// ----------------------------------------------------------------------------
interface sim_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last;

    modport source (output valid, output status, output out_value, output last,
                    input ready);
    modport sink   (input valid, input status, input out_value, input last,
                    output ready);
endinterface

// ===== src/sim_list.sv =====
// ----------------------------------------------------------------------------
// sim_list: one sorted list with parallel compare-and-shift insert
// Every entry compares itself with the new value in the same cycle; entries
// greater than it move up one place and the new value drops into the gap.
// One read port at a pointer-selected index serves the merge.
// ----------------------------------------------------------------------------
module sim_list #(
    parameter int DEPTH = sim_pkg::LIST_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_ins,
    input  logic signed [sim_pkg::DATA_W-1:0]     i_value,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_idx,
    output logic [$clog2(DEPTH + 1)-1:0]          o_count,
    output logic                                  o_full,
    output logic signed [sim_pkg::DATA_W-1:0]     o_rd_data
);
    import sim_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] r_data [DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [DEPTH-1:0]         gt;
    logic [DEPTH-1:0]         wr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;

    // Entries that are held and greater than the new value form a suffix.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_data[i] > i_value);
            wr[i] = gt[i] || (CNT_W'(i) == r_count);
        end
    end

    assign n_count = r_count + CNT_W'(1);

    // Shift the greater entries up and place the new value.
    always_ff @(posedge i_clk) begin
        if (i_ins && !o_full) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (wr[i]) begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                        r_data[i] <= r_data[(i > 0) ? i - 1 : 0];
                    end else begin
                        r_data[i] <= i_value;
                    end
                end
            end
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ins && !o_full) begin
            r_count <= n_count;
        end
    end

    // Merge read port.
    assign o_rd_data = r_data[i_rd_idx];

endmodule

// ===== src/sim_datapath.sv =====
// ----------------------------------------------------------------------------
// sim_datapath: both lists, merge pointers and the result register
// Performs inserts and merge steps on command from the controller and holds
// the payload of the result under transfer.
// ----------------------------------------------------------------------------
module sim_datapath #(
    parameter int LIST_DEPTH = sim_pkg::LIST_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sim_pkg::t_dp_cmd                  i_cmd,
    input  logic                              i_list_select,
    input  logic signed [sim_pkg::DATA_W-1:0] i_value,
    output sim_pkg::t_dp_stat                 o_stat,
    output logic [1:0]                        o_status,
    output logic signed [sim_pkg::DATA_W-1:0] o_out_value,
    output logic                              o_last
);
    import sim_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [CNT_W-1:0]         cnt_a, cnt_b;
    logic                     full_a, full_b;
    logic signed [DATA_W-1:0] head_a, head_b;
    logic                     ins_a, ins_b;
    logic [CNT_W-1:0]         r_ptr_a, r_ptr_b;
    logic [CNT_W-1:0]         ptr_a_inc, ptr_b_inc;
    logic                     avail_a, avail_b;
    logic                     take_a;
    logic                     sel_full;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_last;

    assign ins_a = i_cmd.ld_insert && (i_list_select == LIST_FIRST);
    assign ins_b = i_cmd.ld_insert && (i_list_select == LIST_SECOND);

    sim_list #(.DEPTH(LIST_DEPTH)) u_list_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ins     (ins_a),
        .i_value   (i_value),
        .i_rd_idx  (r_ptr_a[IDX_W-1:0]),
        .o_count   (cnt_a),
        .o_full    (full_a),
        .o_rd_data (head_a)
    );

    sim_list #(.DEPTH(LIST_DEPTH)) u_list_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ins     (ins_b),
        .i_value   (i_value),
        .i_rd_idx  (r_ptr_b[IDX_W-1:0]),
        .o_count   (cnt_b),
        .o_full    (full_b),
        .o_rd_data (head_b)
    );

    // Merge choice: the first list wins on equal values.
    assign avail_a   = (r_ptr_a < cnt_a);
    assign avail_b   = (r_ptr_b < cnt_b);
    assign take_a    = avail_a && (!avail_b || (head_a <= head_b));
    assign ptr_a_inc = r_ptr_a + CNT_W'(1);
    assign ptr_b_inc = r_ptr_b + CNT_W'(1);
    assign sel_full  = (i_list_select == LIST_FIRST) ? full_a : full_b;

    // Status back to the controller.
    always_comb begin
        o_stat.both_empty = (cnt_a == '0) && (cnt_b == '0);
        if (take_a) begin
            o_stat.step_last = (ptr_a_inc == cnt_a) && !avail_b;
        end else begin
            o_stat.step_last = !avail_a && (ptr_b_inc == cnt_b);
        end
    end

    // Merge read pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_merge) begin
            r_ptr_a <= '0;
            r_ptr_b <= '0;
        end else if (i_cmd.step_merge) begin
            if (take_a) begin
                r_ptr_a <= ptr_a_inc;
            end else begin
                r_ptr_b <= ptr_b_inc;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_insert) begin
            r_status <= sel_full ? STAT_DROPPED : STAT_INSERTED;
            r_value  <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.ld_empty) begin
            r_status <= STAT_EMPTY;
            r_value  <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.step_merge) begin
            r_status <= STAT_MERGED;
            r_value  <= take_a ? head_a : head_b;
            r_last   <= o_stat.step_last;
        end
    end

    assign o_status    = r_status;
    assign o_out_value = r_value;
    assign o_last      = r_last;

endmodule

// ===== src/sim_ctrl.sv =====
// ----------------------------------------------------------------------------
// sim_ctrl: controller of the sorted insert and merge block
// Takes commands when the result register is free, runs the merge stream
// one element per free result slot and owns the result valid flag.
// ----------------------------------------------------------------------------
module sim_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_command,
    input  logic               i_out_ready,
    input  sim_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output sim_pkg::t_dp_cmd   o_cmd,
    output sim_pkg::t_state    o_state
);
    import sim_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The result register can take new data when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // State and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    if (i_command == CMD_INSERT) begin
                        o_cmd.ld_insert = 1'b1;
                        n_out_valid     = 1'b1;
                    end else if (i_stat.both_empty) begin
                        o_cmd.ld_empty = 1'b1;
                        n_out_valid    = 1'b1;
                    end else begin
                        o_cmd.start_merge = 1'b1;
                        n_state           = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                if (out_free) begin
                    o_cmd.step_merge = 1'b1;
                    n_out_valid      = 1'b1;
                    if (i_stat.step_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

// ===== src/sorted_insert_and_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_and_merge: two sorted lists with ordered insert and merge
// Commands enter on i_in; each produces results on o_out, the last marked.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command, list_select and value; o_out carries status,
//   out_value and last. Both are valid/ready channels; a transfer happens
//   when valid and ready are high at a rising edge of i_clk.
//   An insert is applied at its transfer by a parallel compare-and-shift
//   across the selected list; its single result appears in the result
//   register in the next cycle, and a new command is taken every cycle
//   while results are drained.
//   A merge moves the controller to its merge state, which then loads the
//   result register one element per cycle while o_out is not stalled,
//   N1 + N2 results in all. Input stays stalled until the final element is
//   loaded; each list has one read port for the merge loop.
//   A merge of two empty lists gives one result in the next cycle.
//   A stall at o_out holds the result register and pauses the merge and
//   input. Reset (i_rst_n low at a clock edge) empties both lists and the
//   result register; list storage itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_and_merge #(
    parameter int LIST_DEPTH = sim_pkg::LIST_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sim_in_if.sink     i_in,
    sim_out_if.source  o_out
);
    import sim_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_state   state;
    logic     in_ready;
    logic     out_valid;

    sim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd),
        .o_state     (state)
    );

    sim_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_list_select (i_in.list_select),
        .i_value       (i_in.value),
        .o_stat        (dp_stat),
        .o_status      (o_out.status),
        .o_out_value   (o_out.out_value),
        .o_last        (o_out.last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

`ifndef SYNTHESIS
    // A final merged element is only shown once the controller is back in idle.
    a_last_merge_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == STAT_MERGED && o_out.last) |-> (state == ST_IDLE))
        else $error("final merged element shown while merge still running");

    // An accepted insert yields exactly one marked insert or drop result.
    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.command == CMD_INSERT) |=>
        (o_out.valid && o_out.last &&
         (o_out.status == STAT_INSERTED || o_out.status == STAT_DROPPED)))
        else $error("insert did not produce its result");

    // Only merged elements carry a nonzero value.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != STAT_MERGED) |-> (o_out.out_value == '0))
        else $error("nonzero value on a non-merge result");
`endif

endmodule
